FILE: sv/pts_pkg.sv
// Shared constants, codes and controller command type for the timer slot table.
`timescale 1ns / 1ps

package pts_pkg;

   localparam int DEF_SLOTS     = 16;
   localparam int DEF_TIME_BITS = 32;
   localparam int MAX_RESULTS   = 16;
   localparam int CNT_BITS      = $clog2(MAX_RESULTS + 1);

   localparam int ID_BITS       = 16;
   localparam int REQ_TIME_BITS = 32;
   localparam int KIND_BITS     = 3;
   localparam int SLOT_OUT_BITS = 4;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_STOP  = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   localparam logic [KIND_BITS-1:0] KIND_STARTED  = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_REJECTED = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_STOPPED  = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_FIRED    = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_IDLE     = 3'd4;

   typedef struct packed {
      logic accept;  // latch request, clear per-request state
      logic rd_en;   // read slot at rd_idx
      logic finish;  // emit the closing result
   } pts_cmd_type;

endpackage

FILE: sv/pts_ctrl.sv
// Sequencer for the slot scan: accept, scan, drain and finish.
`timescale 1ns / 1ps

module pts_ctrl import pts_pkg::*; #(
   parameter int SLOTS = DEF_SLOTS,
   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output pts_cmd_type          cmd,
   output logic [SLOT_BITS-1:0] rd_idx
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic [SLOT_BITS-1:0] cnt_ff;

   assign busy       = (state_ff != ST_IDLE);
   assign cmd.accept = (state_ff == ST_IDLE) && start;
   assign cmd.rd_en  = (state_ff == ST_SCAN);
   assign cmd.finish = (state_ff == ST_FINISH);
   assign rd_idx     = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (start) state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (cnt_ff == SLOT_BITS'(SLOTS - 1)) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DRAIN:  state_ff <= ST_FINISH;
            ST_FINISH: state_ff <= ST_IDLE;
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a start");
   a_finish_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !busy)
      else $error("still busy after finish");
   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> (rd_idx <= SLOT_BITS'(SLOTS - 1)))
      else $error("slot read index out of range");
`endif

endmodule

FILE: sv/pts_dp.sv
// Slot storage, per-slot evaluation and result registers of the timer slot table.
`timescale 1ns / 1ps

module pts_dp import pts_pkg::*; #(
   parameter int SLOTS     = DEF_SLOTS,
   parameter int TIME_BITS = DEF_TIME_BITS,
   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pts_cmd_type              cmd,
   input  logic [SLOT_BITS-1:0]     rd_idx,
   input  logic [1:0]               req_mode,
   input  logic [ID_BITS-1:0]       req_callback_id,
   input  logic [REQ_TIME_BITS-1:0] req_period,
   input  logic [REQ_TIME_BITS-1:0] req_now,
   output logic                     rsp_strobe,
   output logic [KIND_BITS-1:0]     rsp_kind,
   output logic [SLOT_OUT_BITS-1:0] rsp_slot,
   output logic [ID_BITS-1:0]       rsp_fired_id,
   output logic                     rsp_last
);

   localparam int EXT_BITS = TIME_BITS + REQ_TIME_BITS;

   // latched request
   logic [1:0]               mode_ff;
   logic [ID_BITS-1:0]       id_ff;
   logic [REQ_TIME_BITS-1:0] period_ff;
   logic [REQ_TIME_BITS-1:0] now_ff;

   // slot storage
   logic [SLOTS-1:0]         valid_ff;
   logic [ID_BITS-1:0]       owner_mem  [SLOTS];
   logic [REQ_TIME_BITS-1:0] period_mem [SLOTS];
   logic [TIME_BITS-1:0]     expiry_mem [SLOTS];

   // read stage
   logic                     eval_ff;
   logic [SLOT_BITS-1:0]     eval_idx_ff;
   logic [ID_BITS-1:0]       owner_rd_ff;
   logic [REQ_TIME_BITS-1:0] period_rd_ff;
   logic [TIME_BITS-1:0]     expiry_rd_ff;

   // held result: claimed slot on start, latest fired slot on tick
   logic                     pend_ff;
   logic [SLOT_BITS-1:0]     pend_slot_ff;
   logic [ID_BITS-1:0]       pend_id_ff;
   logic [CNT_BITS-1:0]      fire_cnt_ff;

   logic                     rsp_strobe_ff;
   logic [KIND_BITS-1:0]     rsp_kind_ff;
   logic [SLOT_OUT_BITS-1:0] rsp_slot_ff;
   logic [ID_BITS-1:0]       rsp_fired_id_ff;
   logic                     rsp_last_ff;

   logic [EXT_BITS-1:0]      now_ext;
   logic [EXT_BITS-1:0]      per_req_ext;
   logic [EXT_BITS-1:0]      per_rd_ext;
   logic [TIME_BITS-1:0]     now_t;
   logic [TIME_BITS-1:0]     exp_next;
   logic [SLOT_BITS+SLOT_OUT_BITS-1:0] pend_slot_ext;
   logic                     cur_valid;
   logic                     claim;
   logic                     drop;
   logic                     fire;
   logic                     emit_v;
   logic [KIND_BITS-1:0]     emit_kind;
   logic [SLOT_OUT_BITS-1:0] emit_slot;
   logic [ID_BITS-1:0]       emit_id;
   logic                     emit_last;

   always_comb begin
      now_ext       = {{TIME_BITS{1'b0}}, now_ff};
      per_req_ext   = {{TIME_BITS{1'b0}}, period_ff};
      per_rd_ext    = {{TIME_BITS{1'b0}}, period_rd_ff};
      now_t         = now_ext[TIME_BITS-1:0];
      pend_slot_ext = {{SLOT_OUT_BITS{1'b0}}, pend_slot_ff};
      cur_valid     = valid_ff[eval_idx_ff];

      claim = eval_ff && (mode_ff == MODE_START) && !pend_ff && !cur_valid
              && (period_ff != '0);
      drop  = eval_ff && (mode_ff == MODE_STOP) && cur_valid && (owner_rd_ff == id_ff);
      fire  = eval_ff && (mode_ff == MODE_TICK) && cur_valid && !(now_t < expiry_rd_ff)
              && (fire_cnt_ff < CNT_BITS'(MAX_RESULTS));

      // wraps modulo 2^TIME_BITS
      exp_next = now_t + (claim ? per_req_ext[TIME_BITS-1:0] : per_rd_ext[TIME_BITS-1:0]);

      emit_v    = 1'b0;
      emit_kind = KIND_IDLE;
      emit_slot = '0;
      emit_id   = '0;
      emit_last = 1'b1;
      if (fire && pend_ff) begin
         // a later due slot exists, so the held one is not the last
         emit_v    = 1'b1;
         emit_kind = KIND_FIRED;
         emit_slot = pend_slot_ext[SLOT_OUT_BITS-1:0];
         emit_id   = pend_id_ff;
         emit_last = 1'b0;
      end else if (cmd.finish) begin
         unique case (mode_ff)
            MODE_START: begin
               emit_v = 1'b1;
               if (pend_ff) begin
                  emit_kind = KIND_STARTED;
                  emit_slot = pend_slot_ext[SLOT_OUT_BITS-1:0];
                  emit_id   = pend_id_ff;
               end else begin
                  emit_kind = KIND_REJECTED;
               end
            end
            MODE_STOP: begin
               emit_v    = 1'b1;
               emit_kind = KIND_STOPPED;
            end
            MODE_TICK: begin
               emit_v = 1'b1;
               if (pend_ff) begin
                  emit_kind = KIND_FIRED;
                  emit_slot = pend_slot_ext[SLOT_OUT_BITS-1:0];
                  emit_id   = pend_id_ff;
               end else begin
                  emit_kind = KIND_IDLE;
               end
            end
            default: emit_v = 1'b0;  // unused mode: no result
         endcase
      end
   end

   // request latch and storage payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff   <= req_mode;
         id_ff     <= req_callback_id;
         period_ff <= req_period;
         now_ff    <= req_now;
      end
      if (cmd.rd_en) begin
         owner_rd_ff  <= owner_mem[rd_idx];
         period_rd_ff <= period_mem[rd_idx];
         expiry_rd_ff <= expiry_mem[rd_idx];
      end
      eval_idx_ff <= rd_idx;
      if (claim) begin
         owner_mem[eval_idx_ff]  <= id_ff;
         period_mem[eval_idx_ff] <= period_ff;
      end
      if (claim || fire) expiry_mem[eval_idx_ff] <= exp_next;
      if (claim) begin
         pend_slot_ff <= eval_idx_ff;
         pend_id_ff   <= id_ff;
      end else if (fire) begin
         pend_slot_ff <= eval_idx_ff;
         pend_id_ff   <= owner_rd_ff;
      end
      rsp_kind_ff     <= emit_kind;
      rsp_slot_ff     <= emit_slot;
      rsp_fired_id_ff <= emit_id;
      rsp_last_ff     <= emit_last;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         eval_ff       <= 1'b0;
         pend_ff       <= 1'b0;
         fire_cnt_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         eval_ff       <= cmd.rd_en;
         rsp_strobe_ff <= emit_v;
         if (cmd.accept) begin
            pend_ff     <= 1'b0;
            fire_cnt_ff <= '0;
         end else if (claim) begin
            pend_ff <= 1'b1;
         end else if (fire) begin
            pend_ff     <= 1'b1;
            fire_cnt_ff <= fire_cnt_ff + 1'b1;
         end
         if (claim) valid_ff[eval_idx_ff] <= 1'b1;
         else if (drop) valid_ff[eval_idx_ff] <= 1'b0;
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_fired_id = rsp_fired_id_ff;
   assign rsp_last     = rsp_last_ff;

`ifndef SYNTHESIS
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_last_ff |=> !rsp_strobe_ff)
      else $error("result directly after a final result");
   a_fire_limit: assert property (@(posedge clock) disable iff (reset)
      fire_cnt_ff <= CNT_BITS'(MAX_RESULTS))
      else $error("fire count beyond limit");
   a_only_fired_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && (rsp_kind_ff != KIND_FIRED) |-> rsp_last_ff)
      else $error("non-fire result without last");
`endif

endmodule

FILE: sv/periodic_timer_slot_table.sv
// Top level of the periodic timer slot table.
//
// A request (req_mode, req_callback_id, req_period, req_now) is taken at a
// rising edge with start high and busy low. Start claims the lowest free slot,
// stop frees every slot holding the id, tick fires and rearms each due slot
// (at most MAX_RESULTS per tick). Every request walks the whole slot table
// one slot per cycle through the slot memory's single read port, then
// evaluates the last slot (ST_DRAIN) and forms the closing result
// (ST_FINISH); busy stays high throughout, so a new request is taken only
// after the previous one is done. Results come out on rsp_* for exactly one
// cycle, marked by rsp_strobe; the final one of a request has rsp_last set
// and shows in the first cycle with busy low again. A fired result is held
// until the next due slot is found, so all but the last fired result of a
// tick come out while the table is scanned. The receiver cannot stall, so
// results are never held back. An unused mode scans the table but gives no
// result.
// Reset clears all slot valid bits and the sequencer; the slot memories are
// not cleared and need no clearing pass.
`timescale 1ns / 1ps

module periodic_timer_slot_table import pts_pkg::*; #(
   parameter int SLOTS     = DEF_SLOTS,
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_mode,
   input  logic [ID_BITS-1:0]       req_callback_id,
   input  logic [REQ_TIME_BITS-1:0] req_period,
   input  logic [REQ_TIME_BITS-1:0] req_now,
   output logic                     rsp_strobe,
   output logic [KIND_BITS-1:0]     rsp_kind,
   output logic [SLOT_OUT_BITS-1:0] rsp_slot,
   output logic [ID_BITS-1:0]       rsp_fired_id,
   output logic                     rsp_last
);

   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   pts_cmd_type          cmd;
   logic [SLOT_BITS-1:0] rd_idx;

   pts_ctrl #(
      .SLOTS(SLOTS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .rd_idx (rd_idx)
   );

   pts_dp #(
      .SLOTS    (SLOTS),
      .TIME_BITS(TIME_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .rd_idx         (rd_idx),
      .req_mode       (req_mode),
      .req_callback_id(req_callback_id),
      .req_period     (req_period),
      .req_now        (req_now),
      .rsp_strobe     (rsp_strobe),
      .rsp_kind       (rsp_kind),
      .rsp_slot       (rsp_slot),
      .rsp_fired_id   (rsp_fired_id),
      .rsp_last       (rsp_last)
   );

endmodule

FILE: tb/periodic_timer_slot_table_tb.sv
// Self-checking testbench for the periodic timer slot table: directed and random requests.
`timescale 1ns / 1ps

module periodic_timer_slot_table_tb;
   import pts_pkg::*;

   localparam int NUM_SLOTS    = DEF_SLOTS;
   localparam int RAND_REQS    = 75;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 2 * (NUM_SLOTS + 3);
   localparam int MAX_REPORTS  = 10;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]               mode;
      logic [ID_BITS-1:0]       id;
      logic [REQ_TIME_BITS-1:0] period;
      logic [REQ_TIME_BITS-1:0] now;
   } timer_req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]     kind;
      logic [SLOT_OUT_BITS-1:0] slot;
      logic [ID_BITS-1:0]       id;
      logic                     last;
   } timer_rsp_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_mode = MODE_START;
   logic [ID_BITS-1:0]       req_callback_id = '0;
   logic [REQ_TIME_BITS-1:0] req_period = '0;
   logic [REQ_TIME_BITS-1:0] req_now = '0;
   logic                     rsp_strobe;
   logic [KIND_BITS-1:0]     rsp_kind;
   logic [SLOT_OUT_BITS-1:0] rsp_slot;
   logic [ID_BITS-1:0]       rsp_fired_id;
   logic                     rsp_last;

   // shadow of the slot table
   logic                     tbl_valid  [NUM_SLOTS];
   logic [ID_BITS-1:0]       tbl_owner  [NUM_SLOTS];
   logic [REQ_TIME_BITS-1:0] tbl_period [NUM_SLOTS];
   logic [REQ_TIME_BITS-1:0] tbl_expiry [NUM_SLOTS];

   timer_req_type req_queue[$];
   timer_rsp_type predicted_rsps[$];

   int accepted_count = 0;
   int total_reqs     = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   periodic_timer_slot_table u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_callback_id (req_callback_id),
      .req_period      (req_period),
      .req_now         (req_now),
      .rsp_strobe      (rsp_strobe),
      .rsp_kind        (rsp_kind),
      .rsp_slot        (rsp_slot),
      .rsp_fired_id    (rsp_fired_id),
      .rsp_last        (rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void push_rsp(input logic [KIND_BITS-1:0] kind, input int slot,
                                    input logic [ID_BITS-1:0] id, input logic last);
      timer_rsp_type r;
      r.kind = kind;
      r.slot = slot[SLOT_OUT_BITS-1:0];
      r.id   = id;
      r.last = last;
      predicted_rsps.push_back(r);
   endfunction

   // Applies one accepted request to the shadow table and queues its results.
   function automatic void timer_table_step(input timer_req_type r);
      bit claimed;
      int n_due;
      int k;
      claimed = 0;
      n_due   = 0;
      k       = 0;
      unique case (r.mode)
         MODE_START: begin
            if (r.period != '0) begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (!claimed && !tbl_valid[i]) begin
                     claimed       = 1;
                     tbl_valid[i]  = 1'b1;
                     tbl_owner[i]  = r.id;
                     tbl_period[i] = r.period;
                     tbl_expiry[i] = r.now + r.period;
                     push_rsp(KIND_STARTED, i, r.id, 1'b1);
                  end
               end
            end
            if (!claimed)
               push_rsp(KIND_REJECTED, 0, '0, 1'b1);
         end
         MODE_STOP: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (tbl_valid[i] && tbl_owner[i] == r.id)
                  tbl_valid[i] = 1'b0;
            push_rsp(KIND_STOPPED, 0, '0, 1'b1);
         end
         MODE_TICK: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (tbl_valid[i] && r.now >= tbl_expiry[i] && n_due < MAX_RESULTS)
                  n_due++;
            if (n_due == 0)
               push_rsp(KIND_IDLE, 0, '0, 1'b1);
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (tbl_valid[i] && r.now >= tbl_expiry[i] && k < n_due) begin
                  // missed periods are skipped: rearm from now
                  tbl_expiry[i] = r.now + tbl_period[i];
                  push_rsp(KIND_FIRED, i, tbl_owner[i], k == n_due - 1);
                  k++;
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void add_req(input logic [1:0] mode, input logic [ID_BITS-1:0] id,
                                   input logic [REQ_TIME_BITS-1:0] period,
                                   input logic [REQ_TIME_BITS-1:0] now);
      timer_req_type r;
      r.mode   = mode;
      r.id     = id;
      r.period = period;
      r.now    = now;
      req_queue.push_back(r);
   endfunction

   // mostly a small pool so that stops hit running timers
   function automatic logic [ID_BITS-1:0] pick_id();
      logic [ID_BITS-1:0] id;
      if ($urandom_range(99) < 80)
         id = 16'h00A0 + ID_BITS'($urandom_range(0, 7));
      else
         id = ID_BITS'($urandom);
      return id;
   endfunction

   function automatic int sender_idle_pct(input int n);
      int pct;
      if (n < total_reqs / 3)
         pct = 9;
      else if (n < 2 * total_reqs / 3)
         pct = 81;
      else
         pct = 0;
      return pct;
   endfunction

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         tbl_valid[i]  = 1'b0;
         tbl_owner[i]  = '0;
         tbl_period[i] = '0;
         tbl_expiry[i] = '0;
      end
   end

   always @(posedge clock) begin
      timer_req_type nxt;
      timer_req_type cur;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            cur.mode   = req_mode;
            cur.id     = req_callback_id;
            cur.period = req_period;
            cur.now    = req_now;
            timer_table_step(cur);
            accepted_count++;
         end
         if (!start || !busy) begin
            if (req_queue.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct(accepted_count)) begin
               nxt = req_queue.pop_front();
               req_mode        <= nxt.mode;
               req_callback_id <= nxt.id;
               req_period      <= nxt.period;
               req_now         <= nxt.now;
               start           <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      timer_rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (predicted_rsps.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("%0t: unexpected result kind=%0d slot=%0d id=%h last=%b",
                        $realtime, rsp_kind, rsp_slot, rsp_fired_id, rsp_last);
            mismatch_count++;
         end else begin
            want = predicted_rsps.pop_front();
            if (rsp_kind !== want.kind || rsp_slot !== want.slot ||
                rsp_fired_id !== want.id || rsp_last !== want.last) begin
               if (mismatch_count < MAX_REPORTS)
                  $display({"%0t: mismatch exp kind=%0d slot=%0d id=%h last=%b, ",
                            "got kind=%0d slot=%0d id=%h last=%b"},
                           $realtime, want.kind, want.slot, want.id, want.last,
                           rsp_kind, rsp_slot, rsp_fired_id, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic [REQ_TIME_BITS-1:0] tnow;
      logic [REQ_TIME_BITS-1:0] per;
      logic [REQ_TIME_BITS-1:0] at;
      int pick;

      // directed part
      add_req(MODE_TICK, 16'h0000, 32'd0, 32'd0);                   // empty table
      add_req(MODE_START, 16'h1234, 32'd0, 32'd5);                  // zero period
      add_req(MODE_START, 16'h0000, 32'd1, 32'd0);
      add_req(MODE_START, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // expiry wraps
      add_req(MODE_START, 16'h00A5, 32'h8000_0000, 32'h8000_0000);  // wraps to zero
      add_req(MODE_START, 16'h00A5, 32'd10, 32'd0);                 // same id again
      for (int i = 4; i < NUM_SLOTS; i++)
         add_req(MODE_START, 16'h0100 + ID_BITS'(i), 32'd100 + i, 32'd0);
      add_req(MODE_START, 16'h5555, 32'd7, 32'd0);                  // table full
      add_req(MODE_TICK, 16'h0000, 32'd0, 32'hFFFF_FFFF);           // every slot fires
      add_req(MODE_STOP, 16'h00A5, 32'd0, 32'd0);                   // frees two slots
      add_req(MODE_STOP, 16'h4321, 32'd0, 32'd0);                   // id not present
      add_req(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // ignored
      add_req(MODE_TICK, 16'h0000, 32'd0, 32'd0);
      add_req(MODE_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);           // nothing due

      // random part: a running clock with small periods, some noise
      tnow = 32'd1000;
      for (int n = 0; n < RAND_REQS; n++) begin
         tnow = tnow + $urandom_range(0, 20);
         at   = ($urandom_range(99) < 10) ? REQ_TIME_BITS'($urandom) : tnow;
         pick = $urandom_range(99);
         if (pick < 40) begin
            pick = $urandom_range(99);
            if (pick < 85)
               per = $urandom_range(1, 40);
            else if (pick < 95)
               per = $urandom;
            else
               per = '0;
            add_req(MODE_START, pick_id(), per, at);
         end else if (pick < 60) begin
            add_req(MODE_STOP, pick_id(), REQ_TIME_BITS'($urandom), at);
         end else if (pick < 95) begin
            add_req(MODE_TICK, ID_BITS'($urandom), REQ_TIME_BITS'($urandom), at);
         end else begin
            add_req(MODE_UNUSED, ID_BITS'($urandom), REQ_TIME_BITS'($urandom),
                    REQ_TIME_BITS'($urandom));
         end
      end
      total_reqs = req_queue.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_reqs) @(posedge clock);
      while (predicted_rsps.size() != 0) @(posedge clock);
      // an ignored request may still be scanning the table
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
